FILE: hdl/fitt_pkg.sv
// shared types and constants for the integer to text formatter
// no dependencies
`default_nettype none
package fitt_pkg;
	localparam int CHARS = 8;
	localparam int DEPTH = 256;
	localparam int AW = 8;

	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_MIN_DIGITS = 3'd1;
	localparam logic [2:0] REG_GROUP_LENGTH = 3'd2;
	localparam logic [2:0] REG_SEPARATOR = 3'd3;
	localparam logic [2:0] REG_FLAGS = 3'd4;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_H = 8'h68;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS = 8'h2b;

	typedef struct packed {
		logic [63:0] number;
		logic        signed_mode;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_0;
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
		logic [7:0] char_5;
		logic [7:0] char_6;
		logic [7:0] char_7;
		logic [3:0] valid_count;
		logic       last_chunk;
	} out_item_t;

	// classified job handed from the front to the back
	typedef struct packed {
		logic [63:0] value;
		logic [4:0]  base;
		logic [6:0]  md;
		logic [6:0]  gl;
		logic [7:0]  sep;
		logic [6:0]  fl;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		if (d < 4'd10) c = CH_ZERO + {4'd0, d};
		else if (lower) c = 8'h57 + {4'd0, d};
		else c = 8'h37 + {4'd0, d};
		return c;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/fitt_front.sv
// front part: takes items, clamps configuration, handles sign, queues jobs
// depends on fitt_pkg
`default_nettype none
module fitt_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire fitt_pkg::in_item_t in_item,
	input  wire logic              take,
	input  wire logic [4:0]        radix,
	input  wire logic [6:0]        min_digits,
	input  wire logic [6:0]        group_length,
	input  wire logic [7:0]        separator_char,
	input  wire logic [6:0]        format_flags,
	output logic                   full,
	output logic                   job_valid,
	output fitt_pkg::job_t         job
);
	fitt_pkg::job_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	fitt_pkg::job_t nj;
	logic [4:0] b;

	always_comb begin
		b = radix;
		if (b < 5'd2) b = 5'd2;
		if (b > 5'd16) b = 5'd16;
		nj.base = b;
		nj.md = (min_digits > 7'd64) ? 7'd64 : min_digits;
		nj.gl = group_length;
		nj.sep = separator_char;
		nj.fl = format_flags;
		nj.value = in_item.number;
		if (in_item.signed_mode && b == 5'd10 && in_item.number[63]) begin
			nj.value = 64'd0 - in_item.number;
			nj.fl[6] = 1'b1;
		end
	end

	assign full = cnt_q[1];
	assign job_valid = cnt_q != 2'd0;
	assign job = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (start && !full) begin
				q_q[wp_q] <= nj;
				wp_q <= ~wp_q;
			end
			if (take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, start && !full} - {1'b0, take};
		end
	end
endmodule
`default_nettype wire

FILE: hdl/fitt_back.sv
// back part: iterative digit extraction into a text memory, then chunk output
// depends on fitt_pkg
`default_nettype none
module fitt_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire fitt_pkg::job_t     job,
	output logic                    take,
	output logic                    result_valid,
	output fitt_pkg::out_item_t     result
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_DIGIT, ST_SEP, ST_PAD, ST_PRE, ST_OUT
	} state_t;

	state_t st_q;
	fitt_pkg::job_t j_q;
	logic [63:0] quo_q;
	logic [4:0] r_q;
	logic [6:0] bit_q;
	logic [6:0] dc_q, gc_q;
	logic [8:0] wp_q;
	logic [7:0] mem_q [fitt_pkg::DEPTH];
	logic [7:0] last_q;
	logic [1:0] pre_q;
	logic [8:0] rd_q;
	logic [3:0] k_q;
	logic [7:0] chars_q [fitt_pkg::CHARS];
	logic [7:0] rdata;
	logic [3:0] cnt_q;

	// write port
	logic we;
	logic [7:0] wa;
	logic [7:0] wd;
	// prefix decode
	logic pre_we;
	logic [7:0] pre_wd;
	logic [5:0] rtr;

	assign take = st_q == ST_IDLE && job_valid;
	assign rtr = {r_q, quo_q[63]};

	always_comb begin
		result.char_0 = chars_q[0];
		result.char_1 = chars_q[1];
		result.char_2 = chars_q[2];
		result.char_3 = chars_q[3];
		result.char_4 = chars_q[4];
		result.char_5 = chars_q[5];
		result.char_6 = chars_q[6];
		result.char_7 = chars_q[7];
		result.valid_count = cnt_q;
		result.last_chunk = (rd_q == 9'd256);
	end

	// prefix or sign, at most two characters
	always_comb begin
		pre_we = 1'b0;
		pre_wd = 8'd0;
		case (j_q.base)
			5'd2: if (j_q.fl[3]) begin
				pre_we = 1'b1;
				pre_wd = (pre_q == 2'd0) ? fitt_pkg::CH_B : fitt_pkg::CH_ZERO;
			end
			5'd8: if (pre_q == 2'd0 && j_q.fl[4] &&
				last_q != fitt_pkg::CH_ZERO) begin
				pre_we = 1'b1;
				pre_wd = fitt_pkg::CH_ZERO;
			end
			5'd10: if (pre_q == 2'd0 && (j_q.fl[6] || j_q.fl[5])) begin
				pre_we = 1'b1;
				pre_wd = j_q.fl[6] ? fitt_pkg::CH_MINUS : fitt_pkg::CH_PLUS;
			end
			5'd16: if (j_q.fl[2]) begin
				pre_we = 1'b1;
				pre_wd = (pre_q == 2'd0) ? fitt_pkg::CH_X : fitt_pkg::CH_ZERO;
			end
			default: ;
		endcase
	end

	// at most one character written per cycle, just ahead of the text, or at the end for the h suffix
	always_comb begin
		we = 1'b0;
		wa = wp_q[7:0] - 8'd1;
		wd = 8'd0;
		case (st_q)
			ST_IDLE: if (job_valid && job.base == 5'd16 && job.fl[1]) begin
				we = 1'b1;
				wa = 8'd255;
				wd = fitt_pkg::CH_H;
			end
			ST_DIGIT: begin
				we = 1'b1;
				wd = fitt_pkg::digit_char(r_q[3:0], j_q.fl[0]);
			end
			ST_SEP: begin
				we = 1'b1;
				wd = j_q.sep;
			end
			ST_PAD: if (dc_q < j_q.md) begin
				we = 1'b1;
				wd = (j_q.gl != 7'd0 && gc_q == 7'd0) ? j_q.sep : fitt_pkg::CH_ZERO;
			end
			ST_PRE: begin
				we = pre_we && pre_q != 2'd2;
				wd = pre_wd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rdata <= mem_q[rd_q[7:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			result_valid <= 1'b0;
			wp_q <= 9'd256;
			rd_q <= 9'd0;
			k_q <= 4'd0;
			cnt_q <= 4'd0;
		end else begin
			result_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						j_q <= job;
						quo_q <= job.value;
						r_q <= 5'd0;
						bit_q <= 7'd0;
						dc_q <= 7'd0;
						gc_q <= job.gl;
						if (job.base == 5'd16 && job.fl[1]) begin
							wp_q <= 9'd255;
						end else begin
							wp_q <= 9'd256;
						end
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if ({1'b0, rtr} >= {2'b0, j_q.base}) begin
						r_q <= rtr[4:0] - j_q.base;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						r_q <= rtr[4:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'd63) st_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					// quo_q quotient, r_q digit
					last_q <= wd;
					dc_q <= dc_q + 7'd1;
					r_q <= 5'd0;
					bit_q <= 7'd0;
					wp_q <= wp_q - 9'd1;
					if (j_q.gl != 7'd0 && gc_q == 7'd1 && quo_q != 64'd0) begin
						st_q <= ST_SEP;
					end else begin
						if (j_q.gl != 7'd0) gc_q <= gc_q - 7'd1;
						st_q <= (quo_q != 64'd0) ? ST_DIV : ST_PAD;
					end
				end
				ST_SEP: begin
					// separator between digit groups, more digits follow
					wp_q <= wp_q - 9'd1;
					gc_q <= j_q.gl;
					st_q <= ST_DIV;
				end
				ST_PAD: begin
					if (dc_q < j_q.md) begin
						wp_q <= wp_q - 9'd1;
						if (j_q.gl != 7'd0 && gc_q == 7'd0) begin
							gc_q <= j_q.gl;
						end else begin
							last_q <= fitt_pkg::CH_ZERO;
							dc_q <= dc_q + 7'd1;
							if (j_q.gl != 7'd0) gc_q <= gc_q - 7'd1;
						end
					end else begin
						pre_q <= 2'd0;
						st_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					if (we) begin
						wp_q <= wp_q - 9'd1;
						pre_q <= pre_q + 2'd1;
					end else begin
						rd_q <= wp_q;
						k_q <= 4'd0;
						cnt_q <= 4'd0;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// one read per cycle; data arrives in the cycle after the address
					if (k_q != 4'd0) begin
						chars_q[k_q[2:0] - 3'd1] <= rdata;
						cnt_q <= cnt_q + 4'd1;
					end
					if (k_q == 4'd0) begin
						for (int i = 0; i < fitt_pkg::CHARS; i++) chars_q[i] <= 8'd0;
						cnt_q <= 4'd0;
						k_q <= 4'd1;
						rd_q <= rd_q + 9'd1;
					end else if (k_q == 4'd8 || rd_q == 9'd256 &&
						{5'd0, cnt_q} + 9'd1 == {5'd0, k_q}) begin
						result_valid <= 1'b1;
						k_q <= 4'd0;
						if (rd_q == 9'd256) st_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 4'd1;
						rd_q <= rd_q + 9'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/formatted_integer_to_text_unit.sv
// top level of the integer to text formatter
// depends on fitt_pkg, fitt_front and fitt_back
//
// usage:
//   write registers through cfg_we / cfg_index / cfg_data while idle
//   (0 radix, 1 min_digits, 2 group_length, 3 separator_char, 4 format_flags)
//   an item transfer happens when start is high and busy is low
//   each chunk of text appears for one cycle with out_strobe high, up to
//   eight characters in reading order, the final one marked by last_chunk
// rate:
//   a two-entry job queue sits between the front and the back, so busy only
//   rises when both entries are taken
//   the back divides by a restoring divider at one bit a cycle, each digit
//   then written in its own state; padding, separators and prefix are written
//   one character at a time; output reads the text memory one character a cycle
//   a decimal value passes through hand-over, its digits, the padding check
//   and the prefix before its chunks are read out
// reset:
//   arst_n clears the queue and the sequencer; the text memory is left as is
//   the receiver cannot stall: results must be taken as they come
`default_nettype none
module formatted_integer_to_text_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire fitt_pkg::in_item_t  in_item,
	output logic                     out_strobe,
	output fitt_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [7:0]          cfg_data
);
	logic [4:0] radix_q;
	logic [6:0] min_digits_q, group_length_q, format_flags_q;
	logic [7:0] separator_q;
	logic full, job_valid, take;
	fitt_pkg::job_t job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= 5'd10;
			min_digits_q <= 7'd0;
			group_length_q <= 7'd0;
			separator_q <= 8'd44;
			format_flags_q <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				fitt_pkg::REG_RADIX: radix_q <= cfg_data[4:0];
				fitt_pkg::REG_MIN_DIGITS: min_digits_q <= cfg_data[6:0];
				fitt_pkg::REG_GROUP_LENGTH: group_length_q <= cfg_data[6:0];
				fitt_pkg::REG_SEPARATOR: separator_q <= cfg_data;
				fitt_pkg::REG_FLAGS: format_flags_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign busy = full;

	fitt_front u_front (
		.clk, .arst_n, .start, .in_item, .take,
		.radix(radix_q), .min_digits(min_digits_q), .group_length(group_length_q),
		.separator_char(separator_q), .format_flags(format_flags_q),
		.full, .job_valid, .job
	);

	fitt_back u_back (
		.clk, .arst_n, .job_valid, .job, .take,
		.result_valid(out_strobe), .result(out_item)
	);
endmodule
`default_nettype wire

FILE: hdl/fitt_checker.sv
// port level checks for the integer to text formatter
// depends on fitt_pkg; bound to formatted_integer_to_text_unit
`default_nettype none
module fitt_port_checks (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_strobe,
	input wire fitt_pkg::out_item_t out_item
);
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> (out_item.valid_count != 4'd0 && out_item.valid_count <= 4'd8))
		else $error("valid_count out of range");
	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && !out_item.last_chunk |-> out_item.valid_count == 4'd8)
		else $error("short chunk before end");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |=> !out_strobe)
		else $error("back to back chunks");
endmodule

bind formatted_integer_to_text_unit fitt_port_checks u_checker (
	.clk, .arst_n, .out_strobe, .out_item
);
`default_nettype wire
